// ----- design/smsr_pkg.sv -----
// shared constants and types for the shuffled minimal standard generator
// no dependencies; imported by every module of the block and by the testbench
`default_nettype none

package smsr_pkg;

    // generator word: one value of the multiplicative congruential sequence
    typedef logic [30:0] gen_t;

    // input opcodes
    typedef enum logic [0:0] {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } opcode_t;

    // modulus 2^31 - 1 and the minimal standard multiplier
    localparam gen_t        MODULUS      = 31'h7FFF_FFFF;
    localparam logic [14:0] MULTIPLIER   = 15'd16807;
    localparam int          WARMUP_STEPS = 8;

endpackage : smsr_pkg

`default_nettype wire

// ----- design/smsr_mulmod.sv -----
// shared generator step unit: result = operand * 16807 mod (2^31 - 1)
// each step is a product register then a folded reduction; uses smsr_pkg
`default_nettype none

module smsr_mulmod (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire smsr_pkg::gen_t operand,
    output logic               valid,
    output smsr_pkg::gen_t     result
);
    import smsr_pkg::*;

    logic [45:0] prod_reg;
    logic        busy_reg;
    logic        valid_reg;
    gen_t        result_reg;

    logic [31:0] fold_sum;
    logic [31:0] fold_diff;
    gen_t        reduced;

    // control: busy for the reduction cycle, result held valid until next start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b1;
        end
    end

    // 31 x 15 product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 46'(operand) * 46'(MULTIPLIER);
        end
    end

    // 2^31 = 1 mod m: add the high part to the low part, one conditional subtract
    always_comb
    begin
        fold_sum  = {1'b0, prod_reg[30:0]} + 32'(prod_reg[45:31]);
        fold_diff = fold_sum - {1'b0, MODULUS};
        reduced   = (fold_sum >= {1'b0, MODULUS}) ? fold_diff[30:0] : fold_sum[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            result_reg <= reduced;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule : smsr_mulmod

`default_nettype wire

// ----- design/smsr_slotdiv.sv -----
// slot selector: last output divided by the constant slot divisor, by a
// reciprocal estimate then one compare against the next bound; uses smsr_pkg
`default_nettype none

module smsr_slotdiv #(
    parameter int DEPTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire smsr_pkg::gen_t             dividend,
    output logic                            valid,
    output logic [$clog2(DEPTH)-1:0]        slot
);
    import smsr_pkg::*;

    localparam int QW          = $clog2(DEPTH);
    localparam int EW          = QW + 1;
    localparam int MW          = QW + 9;
    localparam int PW          = 31 + MW;
    localparam int BW          = EW + 32;
    localparam int RECIP_SHIFT = 39;
    localparam longint DIVISOR = 1 + (2147483646 / DEPTH);
    localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / DIVISOR;
    localparam logic [MW-1:0] RECIP_W   = MW'(RECIP);
    localparam logic [31:0]   DIVISOR_W = 32'(DIVISOR);
    localparam logic [EW-1:0] SLOT_MAX  = EW'(DEPTH - 1);
    localparam logic [QW-1:0] SLOT_LAST = QW'(DEPTH - 1);

    gen_t           num_reg;
    logic [EW-1:0]  est_reg;
    logic [EW-1:0]  quo_reg;
    logic           busy_reg;
    logic           valid_reg;

    logic [PW-1:0]  est_prod;
    logic [EW-1:0]  est_next;
    logic [BW-1:0]  bound;
    logic           over;

    // control: estimate cycle, then correction cycle; valid held until next start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b1;
        end
    end

    // reciprocal estimate is never high and at most one low
    always_comb
    begin
        est_prod = PW'(dividend) * PW'(RECIP_W);
        est_next = est_prod[RECIP_SHIFT +: EW];
        bound    = (BW'(est_reg) + BW'(1)) * BW'(DIVISOR_W);
        over     = ({{(BW-31){1'b0}}, num_reg} >= bound);
    end

    // datapath: dividend and estimate, then corrected quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            est_reg <= est_next;
        end
        else if (busy_reg)
        begin
            quo_reg <= est_reg + EW'(over);
        end
    end

    // saturate to the last slot
    assign slot  = (quo_reg > SLOT_MAX) ? SLOT_LAST : quo_reg[QW-1:0];
    assign valid = valid_reg;

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (quo_reg <= SLOT_MAX))
        else $error("slot quotient beyond table");
`endif

endmodule : smsr_slotdiv

`default_nettype wire

// ----- design/shuffled_minimal_standard_rng.sv -----
// Shuffled minimal standard random generator.
// Input channel s_axis: tuser carries the opcode (0 = draw, 1 = reseed then
// draw), tdata carries the 31-bit seed. Output channel m_axis: tdata carries
// the 31-bit deviate in 1 .. 2^31-2; one output transaction per input.
// A single step unit (16807 * x mod 2^31-1) serves the warm-up, the table
// fill and the draw; a reciprocal divider picks the slot alongside the step.
// Draw: step, table read, then write-back with the result loaded into the
// output register once it is free; the next input is taken after that.
// Reseed: warm-up and fill run first, serial through the step unit.
// The block takes one item at a time: s_axis_tready is high only while idle.
// A finished result sits in the output register; the block accepts the next
// item meanwhile but holds its result until the receiver takes the first.
// After reset the table is marked unloaded, so the first item reseeds from
// its seed field whatever the opcode. A zero seed, or 2^31-1, acts as one.
// The table comes up undefined; it holds no reset and no clearing pass.
`default_nettype none

module shuffled_minimal_standard_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero fill
    input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [30:0] deviate, [31] zero fill
);
    import smsr_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int TOTAL = TABLE_DEPTH + WARMUP_STEPS;
    localparam int IW    = $clog2(TOTAL);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_CALC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    gen_t            gen_reg, gen_next;
    gen_t            last_reg, last_next;
    logic            out_valid_reg, out_valid_next;
    gen_t            out_data_reg;

    gen_t            table_mem [TABLE_DEPTH];
    gen_t            rd_data_reg;

    logic            mul_start;
    gen_t            mul_operand;
    logic            mul_valid;
    gen_t            mul_result;
    logic            div_start;
    gen_t            div_dividend;
    logic            div_valid;
    logic [AW-1:0]   div_slot;

    logic            in_fire;
    logic            out_free;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            load_out;
    gen_t            seed_fixed;
    opcode_t         opcode;

    // shared step unit and slot divider
    smsr_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .valid   (mul_valid),
        .result  (mul_result)
    );

    smsr_slotdiv #(
        .DEPTH (TABLE_DEPTH)
    ) u_slotdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .valid    (div_valid),
        .slot     (div_slot)
    );

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign opcode     = opcode_t'(s_axis_tuser[0]);
    assign seed_fixed = ((s_axis_tdata[30:0] == '0) || (s_axis_tdata[30:0] == MODULUS))
                        ? gen_t'(1) : s_axis_tdata[30:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gen_next       = gen_reg;
        last_next      = last_reg;
        mul_start      = 1'b0;
        mul_operand    = gen_reg;
        div_start      = 1'b0;
        div_dividend   = last_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = div_slot;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mul_start = 1'b1;
                    if ((opcode == OP_RESEED) || (last_reg == '0))
                    begin
                        mul_operand = seed_fixed;
                        cnt_next    = IW'(TOTAL - 1);
                        state_next  = ST_SEED;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_SEED:
            begin
                if (mul_valid)
                begin
                    // fill runs from the last slot down to slot 0
                    wr_en       = (cnt_reg < IW'(TABLE_DEPTH));
                    wr_addr     = cnt_reg[AW-1:0];
                    mul_start   = 1'b1;
                    mul_operand = mul_result;
                    if (cnt_reg == '0)
                    begin
                        last_next    = mul_result;
                        div_start    = 1'b1;
                        div_dividend = mul_result;
                        state_next   = ST_CALC;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                if (mul_valid && div_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    // refill the slot with the new generator value
                    wr_en      = 1'b1;
                    gen_next   = mul_result;
                    last_next  = rd_data_reg;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gen_reg       <= gen_t'(1);
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gen_reg       <= gen_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= rd_data_reg;
        end
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= mul_result;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[div_slot];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

`ifndef SYNTHESIS
    a_deviate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:0] != '0))
        else $error("zero deviate delivered");

    a_step_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid && (state_reg != ST_IDLE)) |->
            ((mul_result != '0) && (mul_result != MODULUS)))
        else $error("step unit left the field");

    a_loaded_at_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (last_reg != '0))
        else $error("draw with unloaded table");

    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ($past(rd_en) || $stable(rd_data_reg)))
        else $error("result register changed while waiting");
`endif

endmodule : shuffled_minimal_standard_rng

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for shuffled_minimal_standard_rng: randomized stream traffic with a
// built-in shuffle-table predictor and an in-order deviate checker
// depends on smsr_pkg and the shuffled_minimal_standard_rng module

module tb;

    import smsr_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 700;
    // slot = last deviate / (1 + (2^31 - 2) / depth)
    localparam longint unsigned SLOT_DIVISOR = 1 + (longint'(MODULUS) - 1) / TABLE_DEPTH;

    typedef struct {
        opcode_t op;
        gen_t    seed;
        bit      drain;   // hold this one back until all deviates are in
    } rng_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [30:0] seed, [31] zero fill
    logic [0:0]  s_axis_tuser = '0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [30:0] deviate, [31] zero fill

    rng_request_t request_queue[$];
    gen_t         deviate_queue[$];
    int           items_accepted = 0;
    int           total_requests = 1;
    int           fail_count = 0;
    int           cycle_count = 0;

    // predictor state
    gen_t gen_word = 31'd1;
    gen_t shuffle_words[TABLE_DEPTH];
    gen_t last_deviate = '0;

    shuffled_minimal_standard_rng #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // one minimal standard step: 16807 * x mod 2^31-1
    function automatic gen_t minstd_step(gen_t x);
        longint unsigned prod;
        prod = longint'(x) * longint'(MULTIPLIER);
        return gen_t'(prod % longint'(MODULUS));
    endfunction

    // warm-up and table fill from a seed; zero and the modulus act as one
    function automatic void reload_table(gen_t seed);
        gen_t g;
        g = gen_t'(longint'(seed) % longint'(MODULUS));
        if (g == '0)
            g = 31'd1;
        for (int i = TABLE_DEPTH + WARMUP_STEPS - 1; i >= 0; i--)
        begin
            g = minstd_step(g);
            if (i < TABLE_DEPTH)
                shuffle_words[i] = g;
        end
        gen_word     = g;
        last_deviate = shuffle_words[0];
    endfunction

    // expected deviate for one request; an unloaded table forces a reseed
    function automatic gen_t shuffled_deviate(opcode_t op, gen_t seed);
        longint unsigned slot;
        gen_t            picked;
        if (op == OP_RESEED || last_deviate == '0)
            reload_table(seed);
        gen_word = minstd_step(gen_word);
        slot = longint'(last_deviate) / SLOT_DIVISOR;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        picked              = shuffle_words[slot];
        shuffle_words[slot] = gen_word;
        last_deviate        = picked;
        return picked;
    endfunction

    // idle phases follow progress through the stimulus
    function automatic int traffic_phase();
        int p;
        p = items_accepted * 4 / total_requests;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic int sender_idle_pct();
        case (traffic_phase())
            1:       return 45;
            3:       return 16;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (traffic_phase())
            2:       return 45;
            3:       return 16;
            default: return 0;
        endcase
    endfunction

    function automatic void add_request(opcode_t op, gen_t seed, bit drain);
        rng_request_t req;
        req.op    = op;
        req.seed  = seed;
        req.drain = drain;
        request_queue.push_back(req);
    endfunction

    // full-range seeds with the special values mixed in
    function automatic gen_t random_seed();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 31'd1;
            2:       return MODULUS - 31'd1;
            3:       return MODULUS;
            default: return gen_t'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
    endfunction

    // input driver: one transaction per pending request
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit           hold_off;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                deviate_queue.push_back(
                    shuffled_deviate(opcode_t'(s_axis_tuser[0]), s_axis_tdata[30:0]));
                void'(request_queue.pop_front());
                items_accepted++;
            end
            // a pending transaction stays put until taken
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                hold_off = (request_queue.size() == 0);
                if (!hold_off)
                    hold_off = ($urandom_range(0, 99) < sender_idle_pct())
                        || (request_queue[0].drain && deviate_queue.size() != 0);
                if (hold_off)
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, request_queue[0].seed};
                    s_axis_tuser  <= request_queue[0].op;
                end
            end
        end
    end

    // output monitor and receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin : monitor
        gen_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (deviate_queue.size() == 0)
                begin
                    $error("deviate: expected none, actual %0d", m_axis_tdata[30:0]);
                    fail_count++;
                end
                else
                begin
                    want = deviate_queue.pop_front();
                    if (m_axis_tdata[30:0] !== want)
                    begin
                        $error("deviate: expected %0d, actual %0d", want, m_axis_tdata[30:0]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("shuffled_minimal_standard_rng: mismatch");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        opcode_t op;
        // draw on an unloaded table, with a zero seed
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_DRAW, 31'h7FFF_FFFF, 1'b0);
        add_request(OP_DRAW, 31'h1234_5678, 1'b0);
        // seed equal to the modulus
        add_request(OP_RESEED, MODULUS, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        // largest legal seed, then one
        add_request(OP_RESEED, MODULUS - 31'd1, 1'b0);
        add_request(OP_DRAW, MODULUS, 1'b0);
        add_request(OP_RESEED, 31'd1, 1'b0);
        add_request(OP_DRAW, 31'h5555_5555, 1'b0);
        // zero seed on an explicit reseed
        add_request(OP_RESEED, '0, 1'b1);
        add_request(OP_DRAW, 31'h2AAA_AAAA, 1'b0);
        // alternating bit patterns, back-to-back reseeds
        add_request(OP_RESEED, 31'h5555_5555, 1'b0);
        add_request(OP_RESEED, 31'h2AAA_AAAA, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        for (int i = 0; i < 6; i++)
            add_request(OP_DRAW, random_seed(), 1'b0);

        // random traffic, mostly draws with occasional reseeds
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = ($urandom_range(0, 15) == 0) ? OP_RESEED : OP_DRAW;
            add_request(op, random_seed(), (i % 175 == 0) || ($urandom_range(0, 99) == 0));
        end
        total_requests = request_queue.size();

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0)
            @(posedge clk);
        while (deviate_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (fail_count == 0)
            $display("shuffled_minimal_standard_rng: match");
        else
            $display("shuffled_minimal_standard_rng: mismatch");
        $finish;
    end

endmodule
